### rtl/adpcm_two_tap_block_decoder_top_macros.svh
// assertion macros for the two-tap adpcm block decoder
`ifndef ADPCM_TWO_TAP_BLOCK_DECODER_TOP_MACROS_SVH
`define ADPCM_TWO_TAP_BLOCK_DECODER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define ATBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ATBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset
`define ATBD_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### rtl/atbd_pkg.sv
// shared types and constants of the two-tap adpcm block decoder
package atbd_pkg;

  // default configuration
  localparam int CHANNELS_DEF    = 2;
  localparam int DATA_BYTES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 14;
  localparam int ACC_W    = 36;

  // predictor coefficients and sample limits
  localparam logic signed [15:0] COEF_A     = 16'sh7298;
  localparam logic signed [15:0] COEF_B     = 16'sh3350;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  // one data byte handed from the front to the back
  typedef struct packed {
    logic        restart;
    logic        channel;
    logic [7:0]  data_byte;
    logic [15:0] scale;
    logic        last;
  } atbd_cmd_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC
  } atbd_bk_state_t;

endpackage

### rtl/atbd_front.sv
// front end: accepts bytes, tracks frame position and scale, queues data bytes
module atbd_front import atbd_pkg::*; #(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] data_byte,
  input  logic      channel,
  input  logic      restart,
  input  logic      full,
  output logic      push,
  output atbd_cmd_t cmd
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W = $clog2(DATA_BYTES + 2);

  logic [15:0]      scale [CHANNELS];
  logic [POS_W-1:0] pos   [CHANNELS];
  logic             pend_restart;

  logic             accept;
  logic             ch_ok;
  logic [CH_W-1:0]  ch_idx;
  logic [POS_W-1:0] cur_pos;
  logic [15:0]      cur_scale;
  logic             last;

  // handshake and classification
  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign ch_idx    = CH_W'(channel);
  assign ch_ok     = (32'(channel) < CHANNELS);
  assign cur_pos   = restart ? '0 : pos[ch_idx];
  assign cur_scale = restart ? '0 : scale[ch_idx];
  assign last      = (cur_pos == POS_W'(DATA_BYTES + 1));
  assign push      = accept && ch_ok && (cur_pos >= POS_W'(2));

  // queued command
  assign cmd.restart   = pend_restart || restart;
  assign cmd.channel   = channel;
  assign cmd.data_byte = data_byte;
  assign cmd.scale     = cur_scale;
  assign cmd.last      = last;

  // per-channel frame position and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos[c]   <= '0;
        scale[c] <= '0;
      end
    end else if (accept) begin
      if (restart) begin
        for (int c = 0; c < CHANNELS; c++) begin
          pos[c]   <= '0;
          scale[c] <= '0;
        end
      end
      if (ch_ok) begin
        if (cur_pos == POS_W'(0)) begin
          scale[ch_idx] <= {data_byte, cur_scale[7:0]};
          pos[ch_idx]   <= POS_W'(1);
        end else if (cur_pos == POS_W'(1)) begin
          scale[ch_idx] <= {cur_scale[15:8], data_byte};
          pos[ch_idx]   <= POS_W'(2);
        end else begin
          pos[ch_idx]   <= last ? '0 : cur_pos + POS_W'(1);
        end
      end
    end
  end

  // restart waits here until the next data byte carries it to the back
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_restart <= 1'b0;
    end else if (push) begin
      pend_restart <= 1'b0;
    end else if (accept && restart) begin
      pend_restart <= 1'b1;
    end
  end

endmodule

### rtl/atbd_queue.sv
// small command queue between front and back
module atbd_queue import atbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  atbd_cmd_t push_cmd,
  input  logic      pop,
  output atbd_cmd_t pop_cmd,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  atbd_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/atbd_back.sv
// back end: two-tap prediction per nibble, history, output register
module atbd_back import atbd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  atbd_cmd_t                  cmd,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_channel,
  output logic signed [SAMPLE_W-1:0] first_sample,
  output logic signed [SAMPLE_W-1:0] second_sample,
  output logic                       frame_end
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(SAMPLE_MIN);

  atbd_bk_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] prev  [CHANNELS];
  logic signed [SAMPLE_W-1:0] older [CHANNELS];

  logic        nib;
  logic        w_ch;
  logic [7:0]  w_byte;
  logic [15:0] w_scale;
  logic        w_last;
  logic signed [31:0]         m_a;
  logic signed [SAMPLE_W-1:0] sample_a;

  logic                       done;
  logic                       load_out;
  logic [CH_W-1:0]            w_idx;
  logic signed [3:0]          delta;
  logic signed [16:0]         scale_s;
  logic signed [20:0]         prod_d;
  logic signed [31:0]         prod_b;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    q;
  logic signed [SAMPLE_W-1:0] sample;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!empty) state_next = BK_MUL;
      BK_MUL:  state_next = BK_ACC;
      BK_ACC: begin
        if (!nib) begin
          state_next = BK_MUL;
        end else if (!out_valid || !out_stall) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop      = 1'b0;
    done     = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: pop = !empty;
      BK_MUL:  ;
      BK_ACC: begin
        done     = !nib || !out_valid || !out_stall;
        load_out = nib && (!out_valid || !out_stall);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // prediction datapath
  assign w_idx   = CH_W'(w_ch);
  assign delta   = nib ? w_byte[3:0] : w_byte[7:4];
  assign scale_s = $signed({1'b0, w_scale});
  assign prod_d  = delta * scale_s;
  assign prod_b  = COEF_B * older[w_idx];
  assign acc     = ACC_W'(m_a) - ACC_W'(prod_b) + (ACC_W'(prod_d) <<< FRAC_W);
  assign q       = acc >>> FRAC_W;

  // saturation to 16 bits
  always_comb begin
    if (q > Q_MAX) begin
      sample = SAMPLE_MAX;
    end else if (q < Q_MIN) begin
      sample = SAMPLE_MIN;
    end else begin
      sample = q[SAMPLE_W-1:0];
    end
  end

  // working item, first product and nibble select
  always_ff @(posedge clk) begin
    if (pop) begin
      w_ch    <= cmd.channel;
      w_byte  <= cmd.data_byte;
      w_scale <= cmd.scale;
      w_last  <= cmd.last;
    end
    if (state == BK_MUL) begin
      m_a <= COEF_A * prev[w_idx];
    end
    if (done && !nib) begin
      sample_a <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nib <= 1'b0;
    end else if (pop) begin
      nib <= 1'b0;
    end else if (done) begin
      nib <= !nib;
    end
  end

  // per-channel sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev[c]  <= '0;
        older[c] <= '0;
      end
    end else if (pop && cmd.restart) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev[c]  <= '0;
        older[c] <= '0;
      end
    end else if (done) begin
      older[w_idx] <= prev[w_idx];
      prev[w_idx]  <= sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_channel   <= w_ch;
      first_sample  <= sample_a;
      second_sample <= sample;
      frame_end     <= w_last;
    end
  end

endmodule

### rtl/adpcm_two_tap_block_decoder_top.sv
// top level of the two-tap adpcm block decoder
//
//   channel | direction | handshake          | fields
//   input   | in        | in_valid/in_stall   | data_byte, channel, restart
//   output  | out       | out_valid/out_stall | out_channel, first_sample,
//           |           |                     |   second_sample, frame_end
//
// scale bytes and bytes of absent channels are taken by the front end and never queued.
// in the back end a data byte is taken from the queue in BK_IDLE, then per nibble BK_MUL
// forms the previous-sample product and BK_ACC the older-sample product, sum and
// saturation.
// a queue of QUEUE_DEPTH items lets the front keep taking bytes while the back works.
// rst is synchronous and clears positions, scales, history, queue and output valid.
// a stalled result holds in the output register; the back waits only when it has
// a finished item and the register is still full.
module adpcm_two_tap_block_decoder_top import atbd_pkg::*; #(
  parameter int CHANNELS             = CHANNELS_DEF,
  parameter int DATA_BYTES_PER_FRAME = DATA_BYTES_DEF,
  parameter int QUEUE_DEPTH          = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       channel,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_channel,
  output logic signed [SAMPLE_W-1:0] first_sample,
  output logic signed [SAMPLE_W-1:0] second_sample,
  output logic                       frame_end
);

  atbd_cmd_t push_cmd;
  atbd_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // byte classification and frame tracking
  atbd_front #(
    .CHANNELS   (CHANNELS),
    .DATA_BYTES (DATA_BYTES_PER_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .channel   (channel),
    .restart   (restart),
    .full      (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // decoupling queue
  atbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  // sample prediction
  atbd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (pop_cmd),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .frame_end     (frame_end)
  );

endmodule

### rtl/atbd_checker.sv
// port-level checks of the two-tap adpcm block decoder and their binding
`include "adpcm_two_tap_block_decoder_top_macros.svh"

module atbd_checker import atbd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 data_byte,
  input logic                       channel,
  input logic                       restart,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_channel,
  input logic signed [SAMPLE_W-1:0] first_sample,
  input logic signed [SAMPLE_W-1:0] second_sample,
  input logic                       frame_end
);

  // reset leaves a queue that does not stall the input and no result
  `ATBD_ASSERT_RST(a_reset_clear, !out_valid && !in_stall, "reset did not clear state")

  // a waiting input item keeps its fields
  `ATBD_ASSERT_NXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(data_byte) && $stable(channel) && $stable(restart),
    "stalled input item changed")

  // a waiting item keeps its samples
  `ATBD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(first_sample) && $stable(second_sample) &&
    $stable(out_channel) && $stable(frame_end),
    "stalled item changed")

  // only channels that exist give results
  `ATBD_ASSERT_IMP(a_out_channel, out_valid, 32'(out_channel) < CHANNELS, "result on absent channel")

endmodule

bind adpcm_two_tap_block_decoder_top atbd_checker #(
  .CHANNELS (CHANNELS)
) u_atbd_checker (.*);
